>>> rtl/core/mrhb_pkg.sv
// Shared types and constants for the ramped H-bridge motor driver.
// Command and result beat layouts, action codes, register map, reset values.
// No dependencies.
`default_nettype none

package mrhb_pkg;

    // action codes
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_SET  = 2'd1;
    localparam logic [1:0] ACT_STOP = 2'd2;

    // register indexes
    localparam logic REG_RAMP_STEP  = 1'b0;
    localparam logic REG_RAMP_DELAY = 1'b1;

    localparam int          PADDR_W           = 3;
    localparam logic [7:0]  RAMP_STEP_RESET   = 8'd10;
    localparam logic [15:0] RAMP_DELAY_RESET  = 16'd50;
    localparam logic [7:0]  DUTY_MAX          = 8'd100;

    typedef struct packed {
        logic [1:0]        action;
        logic signed [7:0] target_value;
    } cmd_beat_t;

    typedef struct packed {
        logic              dir_in_line;
        logic              dir_out_line;
        logic [6:0]        duty_out;
        logic [6:0]        duty_in;
        logic signed [7:0] level_now;
        logic              ramping;
    } res_beat_t;

endpackage

`default_nettype wire

>>> rtl/core/motor_ramp_hbridge_driver.sv
// Top level of the ramped H-bridge motor driver: APB registers, ramp state,
// bridge output decode and a two-entry result buffer. Depends on mrhb_pkg.
`default_nettype none

// One command beat (tick, set or stop) is taken per clock while s_ready is high and
// yields exactly one registered result beat. The ramp state is updated by a single pass
// of narrow add/compare logic at the input handshake; the result is written
// into a two-entry output buffer, so commands keep flowing while one result
// waits on m_ready, and s_ready drops only when both entries are full.
// Registers: ramp_step at 0x0, ramp_delay_ticks at 0x4; write them only
// while no beat is in flight.
module motor_ramp_hbridge_driver (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [2:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic      [31:0]             prdata,
    output logic                         pready,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire mrhb_pkg::cmd_beat_t     s_data,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output mrhb_pkg::res_beat_t          m_data
);
    import mrhb_pkg::*;

    logic [7:0]        step_reg;
    logic [15:0]       delay_reg;
    logic signed [7:0] target_reg, target_next;
    logic signed [7:0] level_reg, level_next;
    logic signed [7:0] prev_reg, prev_next;
    logic [15:0]       count_reg, count_next;
    logic              armed_reg, armed_next;

    res_beat_t         head_reg, head_next;
    res_beat_t         tail_reg, tail_next;
    logic [1:0]        fill_reg, fill_next;

    logic              cfg_wr;
    logic              push, pop;
    logic [15:0]       arm_value;
    logic signed [9:0] cur_w, tgt_w, up_w, dn_w;
    logic signed [7:0] ramp_lvl;
    logic [7:0]        mag;
    res_beat_t         res;

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[2])
            REG_RAMP_STEP:  prdata = {24'd0, step_reg};
            REG_RAMP_DELAY: prdata = {16'd0, delay_reg};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= RAMP_STEP_RESET;
            delay_reg <= RAMP_DELAY_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_RAMP_STEP) begin
                step_reg <= pwdata[7:0];
            end else begin
                delay_reg <= pwdata[15:0];
            end
        end
    end

    // ---------------- ramp update ----------------
    assign s_ready   = (fill_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign pop       = m_valid && m_ready;
    assign arm_value = (delay_reg == 16'd0) ? 16'd1 : delay_reg;

    assign cur_w = 10'(level_reg);
    assign tgt_w = 10'(target_reg);
    assign up_w  = cur_w + $signed({2'b00, step_reg});
    assign dn_w  = cur_w - $signed({2'b00, step_reg});

    // step toward target; a sign reversal against the previous level parks at 0
    always_comb begin
        if (tgt_w > up_w) begin
            ramp_lvl = up_w[7:0];
        end else if (tgt_w < dn_w) begin
            ramp_lvl = dn_w[7:0];
        end else begin
            ramp_lvl = target_reg;
        end
        if ((prev_reg < 0 && ramp_lvl > 0) || (prev_reg > 0 && ramp_lvl < 0)) begin
            ramp_lvl = 8'sd0;
        end
    end

    always_comb begin
        target_next = target_reg;
        level_next  = level_reg;
        prev_next   = prev_reg;
        count_next  = count_reg;
        armed_next  = armed_reg;
        case (s_data.action)
            ACT_SET, ACT_STOP: begin
                if (s_data.action == ACT_SET) begin
                    if (s_data.target_value != level_reg) begin
                        target_next = s_data.target_value;
                        count_next  = arm_value;
                        armed_next  = 1'b1;
                    end
                end else if (level_reg != 8'sd0) begin
                    target_next = 8'sd0;
                    count_next  = arm_value;
                    armed_next  = 1'b1;
                end
            end
            ACT_TICK: begin
                if (armed_reg) begin
                    if (count_reg <= 16'd1) begin
                        level_next = ramp_lvl;
                        prev_next  = ramp_lvl;
                        if (target_reg != ramp_lvl) begin
                            count_next = arm_value;
                            armed_next = 1'b1;
                        end else begin
                            count_next = 16'd0;
                            armed_next = 1'b0;
                        end
                    end else begin
                        count_next = count_reg - 16'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= 8'sd0;
            level_reg  <= 8'sd0;
            prev_reg   <= 8'sd0;
            count_reg  <= 16'd0;
            armed_reg  <= 1'b0;
        end else if (push) begin
            target_reg <= target_next;
            level_reg  <= level_next;
            prev_reg   <= prev_next;
            count_reg  <= count_next;
            armed_reg  <= armed_next;
        end
    end

    // ---------------- bridge decode ----------------
    always_comb begin
        mag = (level_next < 0) ? 8'(-level_next) : 8'(level_next);
        if (mag > DUTY_MAX) begin
            mag = DUTY_MAX;
        end
        res.dir_in_line  = (level_next < 0);
        res.dir_out_line = (level_next > 0);
        res.duty_out     = (level_next > 0) ? mag[6:0] : 7'd0;
        res.duty_in      = (level_next < 0) ? mag[6:0] : 7'd0;
        res.level_now    = level_next;
        res.ramping      = armed_next;
    end

    // ---------------- result buffer ----------------
    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        case (fill_reg)
            2'd0: begin
                if (push) begin
                    head_next = res;
                    fill_next = 2'd1;
                end
            end
            2'd1: begin
                if (push && pop) begin
                    head_next = res;
                end else if (push) begin
                    tail_next = res;
                    fill_next = 2'd2;
                end else if (pop) begin
                    fill_next = 2'd0;
                end
            end
            2'd2: begin
                if (pop) begin
                    head_next = tail_reg;
                    fill_next = 2'd1;
                end
            end
            default: begin
                fill_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
        if (!aresetn) begin
            fill_reg <= 2'd0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    assign m_valid = (fill_reg != 2'd0);
    assign m_data  = head_reg;

endmodule

`default_nettype wire

>>> dv/motor_ramp_hbridge_driver_test.sv
// Testbench for motor_ramp_hbridge_driver: a directed command table, then random
// command streams under several ramp settings, every result beat checked.
// Depends on mrhb_pkg and the motor_ramp_hbridge_driver RTL.
`timescale 1ns / 1ps

module motor_ramp_hbridge_driver_test;
    import mrhb_pkg::*;

    // action 3 is not decoded by the block: no state change, not a tick
    localparam logic [1:0] ACT_SPARE   = 2'd3;
    localparam int         RUN_LIMIT   = 200000;
    localparam int         HOLD_CYCLES = 300;
    localparam int         N_PHASES    = 8;

    logic aclk = 1'b0;
    always #6 aclk = ~aclk;

    logic                 aresetn = 1'b0;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [PADDR_W-1:0]   paddr   = '0;
    logic [31:0]          pwdata  = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    cmd_beat_t            s_data  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    res_beat_t            m_data;

    motor_ramp_hbridge_driver dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ---------------------------------------------------------------- ramp predictor
    logic [7:0]  ramp_step_q;
    logic [15:0] ramp_delay_q;
    int          goal_lvl;
    int          cur_lvl;
    int          last_lvl;
    int unsigned wait_cnt;
    bit          wait_armed;

    res_beat_t   pending_bridge[$];
    int          errors = 0;
    int          cycles = 0;
    bit          steady = 1'b0;
    int          hold_asks = 0;
    int          hold_done = 0;
    int          hold_left = 0;

    function automatic void arm_wait();
        wait_cnt   = (ramp_delay_q == 16'd0) ? 1 : ramp_delay_q;
        wait_armed = 1'b1;
    endfunction

    function automatic void ramp_move();
        int s;
        int nxt;
        s = int'(ramp_step_q);
        if (goal_lvl > cur_lvl + s)
            nxt = cur_lvl + s;
        else if (goal_lvl < cur_lvl - s)
            nxt = cur_lvl - s;
        else
            nxt = goal_lvl;
        // never step straight across zero: park at 0 first
        if ((last_lvl < 0 && nxt > 0) || (last_lvl > 0 && nxt < 0))
            nxt = 0;
        cur_lvl  = nxt;
        last_lvl = nxt;
        if (goal_lvl != cur_lvl) begin
            arm_wait();
        end else begin
            wait_armed = 1'b0;
            wait_cnt   = 0;
        end
    endfunction

    function automatic res_beat_t bridge_after(cmd_beat_t c);
        int        v;
        int        mag;
        res_beat_t r;
        case (c.action)
            ACT_SET, ACT_STOP: begin
                v = (c.action == ACT_SET) ? int'($signed(c.target_value)) : 0;
                if (v != cur_lvl) begin
                    goal_lvl = v;
                    arm_wait();
                end
            end
            ACT_TICK: begin
                if (wait_armed) begin
                    if (wait_cnt <= 1)
                        ramp_move();
                    else
                        wait_cnt--;
                end
            end
            default: ;
        endcase
        mag = (cur_lvl < 0) ? -cur_lvl : cur_lvl;
        if (mag > int'(DUTY_MAX))
            mag = int'(DUTY_MAX);
        r.dir_in_line  = (cur_lvl < 0);
        r.dir_out_line = (cur_lvl > 0);
        r.duty_out     = (cur_lvl > 0) ? mag[6:0] : 7'd0;
        r.duty_in      = (cur_lvl < 0) ? mag[6:0] : 7'd0;
        r.level_now    = cur_lvl[7:0];
        r.ramping      = wait_armed;
        return r;
    endfunction

    // ---------------------------------------------------------------- directed table
    typedef struct {
        bit        cfg;
        logic      reg_sel;
        logic [15:0] reg_val;
        cmd_beat_t cmd;
        bit        typed;
        res_beat_t want;
    } plan_row_t;

    plan_row_t plan[$];

    function automatic plan_row_t cmd_row(logic [1:0] a, logic [7:0] v);
        plan_row_t r;
        r = '{default: '0};
        r.cmd.action       = a;
        r.cmd.target_value = v;
        return r;
    endfunction

    function automatic plan_row_t chk_row(logic [1:0] a, logic [7:0] v, res_beat_t want);
        plan_row_t r;
        r       = cmd_row(a, v);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic plan_row_t cfg_row(logic sel, logic [15:0] val);
        plan_row_t r;
        r         = '{default: '0};
        r.cfg     = 1'b1;
        r.reg_sel = sel;
        r.reg_val = val;
        return r;
    endfunction

    // ---------------------------------------------------------------- drivers
    function automatic void check_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (want !== got) begin
            errors++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    task automatic push_cmd(input cmd_beat_t c, input bit typed, input res_beat_t want);
        res_beat_t p;
        if (!steady && $urandom_range(99) < 13) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        p = bridge_after(c);
        pending_bridge.push_back(typed ? want : p);
    endtask

    task automatic drain();
        while (pending_bridge.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic sel, input logic [15:0] val);
        logic [31:0] junk;
        logic [31:0] want;
        junk    = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= (sel == REG_RAMP_STEP) ? {junk[31:8], val[7:0]} : {junk[31:16], val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (sel == REG_RAMP_STEP)
            ramp_step_q = val[7:0];
        else
            ramp_delay_q = val;
        want = (sel == REG_RAMP_STEP) ? {24'd0, ramp_step_q} : {16'd0, ramp_delay_q};
        // read back on the same address
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        check_field(sel == REG_RAMP_STEP ? "prdata ramp_step" : "prdata ramp_delay_ticks",
                    want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic cmd_beat_t random_cmd();
        int        roll;
        cmd_beat_t c;
        roll           = $urandom_range(99);
        c.target_value = 8'($urandom);
        if (roll < 68) begin
            c.action = ACT_TICK;
        end else if (roll < 86) begin
            c.action = ACT_SET;
            if ($urandom_range(3) == 0) begin
                case ($urandom_range(4))
                    0: c.target_value = 8'h80;
                    1: c.target_value = 8'h7f;
                    2: c.target_value = 8'h00;
                    3: c.target_value = 8'd100;
                    default: c.target_value = 8'h9b;  // -101
                endcase
            end
        end else if (roll < 90) begin
            c.action       = ACT_SET;
            c.target_value = cur_lvl[7:0];   // set to the present level: ignored
        end else if (roll < 96) begin
            c.action = ACT_STOP;
        end else begin
            c.action = ACT_SPARE;
        end
        return c;
    endfunction

    // ---------------------------------------------------------------- receiver
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_done != hold_asks) begin
            hold_done <= hold_done + 1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= 13);
        end
    end

    // ---------------------------------------------------------------- result check
    always @(posedge aclk) begin : result_check
        res_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_bridge.size() == 0) begin
                errors++;
                $error("result beat with no command waiting");
            end else begin
                want = pending_bridge.pop_front();
                check_field("dir_in_line", 32'(want.dir_in_line), 32'(m_data.dir_in_line));
                check_field("dir_out_line", 32'(want.dir_out_line),
                            32'(m_data.dir_out_line));
                check_field("duty_out", 32'(want.duty_out), 32'(m_data.duty_out));
                check_field("duty_in", 32'(want.duty_in), 32'(m_data.duty_in));
                check_field("level_now", 32'($signed(want.level_now)),
                            32'($signed(m_data.level_now)));
                check_field("ramping", 32'(want.ramping), 32'(m_data.ramping));
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    int phase_step  [N_PHASES] = '{10, 255, 1, 0, 37, 200, 128, 3};
    int phase_delay [N_PHASES] = '{50, 0, 1, 3, 2, 65535, 1, 7};
    int phase_items [N_PHASES] = '{200, 120, 130, 110, 120, 40, 120, 110};

    initial begin
        ramp_step_q  = RAMP_STEP_RESET;
        ramp_delay_q = RAMP_DELAY_RESET;
        goal_lvl     = 0;
        cur_lvl      = 0;
        last_lvl     = 0;
        wait_cnt     = 0;
        wait_armed   = 1'b0;

        // reset values, ignored items, then full-scale swings with step 255
        plan.push_back(chk_row(ACT_TICK,  8'h7f, '0));
        plan.push_back(chk_row(ACT_SPARE, 8'h80, '0));
        plan.push_back(chk_row(ACT_STOP,  8'hff, '0));
        plan.push_back(chk_row(ACT_SET,   8'h00, '0));
        plan.push_back(chk_row(ACT_SET,   8'h7f, '{1'b0, 1'b0, 7'd0, 7'd0, 8'h00, 1'b1}));
        plan.push_back(cfg_row(REG_RAMP_STEP, 16'd255));
        plan.push_back(cfg_row(REG_RAMP_DELAY, 16'd0));
        plan.push_back(chk_row(ACT_SET,   8'h7f, '{1'b0, 1'b0, 7'd0, 7'd0, 8'h00, 1'b1}));
        plan.push_back(chk_row(ACT_TICK,  8'h00, '{1'b0, 1'b1, 7'd100, 7'd0, 8'h7f, 1'b0}));
        plan.push_back(chk_row(ACT_SET,   8'h80, '{1'b0, 1'b1, 7'd100, 7'd0, 8'h7f, 1'b1}));
        // crossing zero parks the level at 0 first
        plan.push_back(chk_row(ACT_TICK,  8'hc3, '{1'b0, 1'b0, 7'd0, 7'd0, 8'h00, 1'b1}));
        plan.push_back(chk_row(ACT_TICK,  8'h3c, '{1'b1, 1'b0, 7'd0, 7'd100, 8'h80, 1'b0}));
        plan.push_back(chk_row(ACT_STOP,  8'h5a, '{1'b1, 1'b0, 7'd0, 7'd100, 8'h80, 1'b1}));
        plan.push_back(chk_row(ACT_TICK,  8'ha5, '0));
        // zero step: level holds while the delay keeps rearming
        plan.push_back(cfg_row(REG_RAMP_STEP, 16'd0));
        plan.push_back(chk_row(ACT_SET,   8'h05, '{1'b0, 1'b0, 7'd0, 7'd0, 8'h00, 1'b1}));
        plan.push_back(chk_row(ACT_TICK,  8'hff, '{1'b0, 1'b0, 7'd0, 7'd0, 8'h00, 1'b1}));
        plan.push_back(chk_row(ACT_SET,   8'h00, '{1'b0, 1'b0, 7'd0, 7'd0, 8'h00, 1'b1}));
        plan.push_back(chk_row(ACT_TICK,  8'h01, '{1'b0, 1'b0, 7'd0, 7'd0, 8'h00, 1'b1}));
        // step change while armed takes effect at the next update
        plan.push_back(cfg_row(REG_RAMP_STEP, 16'd1));
        plan.push_back(cfg_row(REG_RAMP_DELAY, 16'd2));
        plan.push_back(cmd_row(ACT_TICK,  8'h80));
        plan.push_back(cmd_row(ACT_TICK,  8'h7f));
        plan.push_back(cmd_row(ACT_SET,   8'hfd));
        plan.push_back(cmd_row(ACT_TICK,  8'h00));
        plan.push_back(cmd_row(ACT_TICK,  8'hff));
        plan.push_back(cmd_row(ACT_SPARE, 8'h33));
        plan.push_back(cmd_row(ACT_TICK,  8'h00));
        plan.push_back(cmd_row(ACT_TICK,  8'h00));
        plan.push_back(cmd_row(ACT_STOP,  8'h7f));
        plan.push_back(cmd_row(ACT_TICK,  8'h00));
        plan.push_back(cmd_row(ACT_TICK,  8'h00));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].cfg) begin
                s_valid <= 1'b0;
                drain();
                write_reg(plan[i].reg_sel, plan[i].reg_val);
            end else begin
                push_cmd(plan[i].cmd, plan[i].typed, plan[i].want);
            end
        end
        s_valid <= 1'b0;

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            if (p == N_PHASES - 1) begin
                phase_step[p]  = $urandom_range(255);
                phase_delay[p] = $urandom_range(1, 12);
            end
            write_reg(REG_RAMP_STEP, 16'(phase_step[p]));
            write_reg(REG_RAMP_DELAY, 16'(phase_delay[p]));
            steady <= (p == 2);
            // long receiver hold-off: the output buffer fills and s_ready drops
            if (p == 1 || p == 4)
                hold_asks <= hold_asks + 1;
            for (int n = 0; n < phase_items[p]; n++)
                push_cmd(random_cmd(), 1'b0, '0);
            s_valid <= 1'b0;
        end

        drain();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
